FILE: hw/rtl/mwo_pkg.sv
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types and constants of the mipmapped wavetable oscillator.
// ----------------------------------------------------------------------------
package mwo_pkg;

   localparam int PHASE_BITS  = 32;
   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = 16;

   localparam int REQ_DATA_W = 80;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int SEL_FIELD_W = 3;
   localparam int IDX_FIELD_W = 12;
   localparam int LEN_FIELD_W = 4;
   localparam int TIU_W       = 4;
   localparam int STEP_W      = 3;

   typedef logic [1:0] op_type;
   localparam op_type OP_TICK   = 2'd0;
   localparam op_type OP_SAMPLE = 2'd1;
   localparam op_type OP_DESC   = 2'd2;

   typedef enum logic [2:0] {
      CSR_PHASE_INC     = 3'd0,
      CSR_PHASE_SHIFT   = 3'd1,
      CSR_PULSE_OFFSET  = 3'd2,
      CSR_OUTPUT_MODE   = 3'd3,
      CSR_TABLES_IN_USE = 3'd4
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic s0_load;
      logic mul_en;
      logic sum_en;
      logic a_load;
   } interp_ctl_type;

   localparam logic [PHASE_BITS-1:0] PULSE_OFFSET_RESET = PHASE_BITS'(1) << (PHASE_BITS - 1);

   localparam logic [STEP_W-1:0] STEP_LAST_PLAIN = 3'd4;
   localparam logic [STEP_W-1:0] STEP_LAST_PULSE = 3'd6;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

endpackage

FILE: hw/rtl/mipmapped_wavetable_oscillator.sv
// ----------------------------------------------------------------------------
// mipmapped_wavetable_oscillator
// Band-limited wavetable oscillator with per-band tables and linear interpolation.
// ----------------------------------------------------------------------------
// Table writes and non-producing ticks: one transfer per cycle while idle.
// Producing tick: the sequencer reads two samples (plain) or four (pulse) through the
// single sample-memory read port, then runs the multiply and add stages; the result is
// registered and the next input is taken back in idle, once the output register is free.
// Synchronous reset clears phase, registers (pulse offset to one half) and descriptors;
// the sample memory is not cleared.
module mipmapped_wavetable_oscillator
   import mwo_pkg::*;
#(
   parameter int TABLE_SLOTS  = 8,
   parameter int MAX_LEN_LOG2 = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // produce, table_select, sample_index, sample_value, top_frequency, length_log2
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // operation
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // sample
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int LEN_W  = $clog2(MAX_LEN_LOG2 + 1);
   localparam int ADDR_W = SLOT_W + MAX_LEN_LOG2;
   localparam int DEPTH  = TABLE_SLOTS * (2 ** MAX_LEN_LOG2);

   // request fields
   logic                   req_produce;
   logic [SEL_FIELD_W-1:0] req_table_select;
   logic [IDX_FIELD_W-1:0] req_sample_index;
   logic [SAMPLE_BITS-1:0] req_sample_value;
   logic [PHASE_BITS-1:0]  req_top_frequency;
   logic [LEN_FIELD_W-1:0] req_length_log2;
   op_type                 req_operation;

   assign req_produce       = req_tdata[0];
   assign req_table_select  = req_tdata[3:1];
   assign req_sample_index  = req_tdata[15:4];
   assign req_sample_value  = req_tdata[39:16];
   assign req_top_frequency = req_tdata[71:40];
   assign req_length_log2   = req_tdata[75:72];
   assign req_operation     = req_tuser[1:0];

   // configuration registers
   logic [PHASE_BITS-1:0] phase_inc_ff;
   logic [PHASE_BITS-1:0] phase_shift_ff;
   logic [PHASE_BITS-1:0] pulse_offset_ff;
   logic                  output_mode_ff;
   logic [TIU_W-1:0]      tables_in_use_ff;
   logic                  csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff     <= '0;
         phase_shift_ff   <= '0;
         pulse_offset_ff  <= PULSE_OFFSET_RESET;
         output_mode_ff   <= 1'b0;
         tables_in_use_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_index_type'(csr_paddr[4:2]))
            CSR_PHASE_INC:     phase_inc_ff     <= csr_pwdata[PHASE_BITS-1:0];
            CSR_PHASE_SHIFT:   phase_shift_ff   <= csr_pwdata[PHASE_BITS-1:0];
            CSR_PULSE_OFFSET:  pulse_offset_ff  <= csr_pwdata[PHASE_BITS-1:0];
            CSR_OUTPUT_MODE:   output_mode_ff   <= csr_pwdata[0];
            CSR_TABLES_IN_USE: tables_in_use_ff <= csr_pwdata[TIU_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index_type'(csr_paddr[4:2]))
         CSR_PHASE_INC:     csr_prdata = phase_inc_ff;
         CSR_PHASE_SHIFT:   csr_prdata = phase_shift_ff;
         CSR_PULSE_OFFSET:  csr_prdata = pulse_offset_ff;
         CSR_OUTPUT_MODE:   csr_prdata = CSR_DATA_W'(output_mode_ff);
         CSR_TABLES_IN_USE: csr_prdata = CSR_DATA_W'(tables_in_use_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // input decode
   state_type            state_ff, state_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 req_xfer;
   logic                 slot_ok;
   logic                 idx_ok;
   logic                 sample_we;
   logic                 desc_we;
   logic                 tick;
   logic                 start;
   logic [LEN_W-1:0]     len_sat;
   logic [SLOT_W-1:0]    req_slot;
   logic [ADDR_W-1:0]    wr_addr;

   assign req_xfer  = req_tvalid && req_tready;
   assign slot_ok   = 5'(req_table_select) < 5'(TABLE_SLOTS);
   assign idx_ok    = 17'(req_sample_index) < 17'(2 ** MAX_LEN_LOG2);
   assign sample_we = req_xfer && (req_operation == OP_SAMPLE) && slot_ok && idx_ok;
   assign desc_we   = req_xfer && (req_operation == OP_DESC) && slot_ok;
   assign tick      = req_xfer && (req_operation == OP_TICK);
   assign start     = tick && req_produce;
   assign len_sat   = (5'(req_length_log2) > 5'(MAX_LEN_LOG2)) ? LEN_W'(MAX_LEN_LOG2)
                                                             : LEN_W'(req_length_log2);
   assign req_slot  = SLOT_W'(req_table_select);
   assign wr_addr   = {req_slot, MAX_LEN_LOG2'(req_sample_index)};

   // phase and read positions
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] phase_next;
   logic [PHASE_BITS-1:0] pos_a_ff, pos_a_in;
   logic [PHASE_BITS-1:0] pos_b_ff, pos_b_in;

   always_comb begin
      phase_next = phase_ff + phase_inc_ff;
      phase_in   = tick ? phase_next : phase_ff;
      pos_a_in   = phase_ff + (output_mode_ff ? '0 : phase_shift_ff);
      pos_b_in   = phase_ff + pulse_offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         pos_a_ff <= pos_a_in;
         pos_b_ff <= pos_b_in;
      end
   end

   // table selection
   logic [SLOT_W-1:0] sel_slot;
   logic [LEN_W-1:0]  sel_len;

   mwo_select #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .SLOT_W      (SLOT_W),
      .LEN_W       (LEN_W)
   ) u_select (
      .clock         (clock),
      .reset         (reset),
      .desc_we       (desc_we),
      .desc_slot     (req_slot),
      .desc_top      (req_top_frequency),
      .desc_len      (len_sat),
      .phase_inc     (phase_inc_ff),
      .tables_in_use (tables_in_use_ff),
      .sel_en        (start),
      .sel_slot      (sel_slot),
      .sel_len       (sel_len)
   );

   // read addressing: steps 0..1 read first position, 2..3 second; odd steps take i+1
   logic [PHASE_BITS-1:0]   pos_rd;
   logic [PHASE_BITS-1:0]   pos_w;
   logic [PHASE_BITS-1:0]   pos_sh;
   logic [MAX_LEN_LOG2-1:0] top_bits;
   logic [MAX_LEN_LOG2-1:0] lmask;
   logic [MAX_LEN_LOG2-1:0] idx0;
   logic [MAX_LEN_LOG2-1:0] idx1;
   logic [LEN_W-1:0]        shamt;
   logic [ADDR_W-1:0]       rd_addr;
   logic [FRAC_BITS-1:0]    weight;

   always_comb begin
      pos_rd   = step_ff[1] ? pos_b_ff : pos_a_ff;
      top_bits = pos_rd[PHASE_BITS-1 -: MAX_LEN_LOG2];
      shamt    = LEN_W'(MAX_LEN_LOG2) - sel_len;
      idx0     = top_bits >> shamt;
      lmask    = MAX_LEN_LOG2'(((MAX_LEN_LOG2 + 1)'(1) << sel_len) - (MAX_LEN_LOG2 + 1)'(1));
      idx1     = (idx0 + MAX_LEN_LOG2'(1)) & lmask;
      rd_addr  = {sel_slot, step_ff[0] ? idx1 : idx0};
      pos_w    = step_ff[2] ? pos_b_ff : pos_a_ff;
      pos_sh   = pos_w << sel_len;
      weight   = pos_sh[PHASE_BITS-1 -: FRAC_BITS];
   end

   // sample memory; writes are taken only while idle, so no read overlaps a write
   logic [SAMPLE_BITS-1:0] rd_data;

   mwo_table_ram #(
      .ADDR_W (ADDR_W),
      .DEPTH  (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (sample_we),
      .wr_addr (wr_addr),
      .wr_data (req_sample_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer
   logic [STEP_W-1:0] last_step;
   logic              at_last;
   logic              rsp_free;
   logic              rsp_load;
   interp_ctl_type    ctl;

   assign last_step = output_mode_ff ? STEP_LAST_PULSE : STEP_LAST_PLAIN;
   assign at_last   = (step_ff == last_step);
   assign rsp_free  = !rsp_tvalid || rsp_tready;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
               step_in  = '0;
            end
         end
         ST_READ: begin
            if (at_last) begin
               if (rsp_free) begin
                  state_in = ST_IDLE;
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      req_tready  = 1'b0;
      rsp_load    = 1'b0;
      ctl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_READ: begin
            ctl.s0_load = (step_ff == 3'd1) || (output_mode_ff && step_ff == 3'd3);
            ctl.mul_en  = (step_ff == 3'd2) || (output_mode_ff && step_ff == 3'd4);
            ctl.sum_en  = (step_ff == 3'd3) || (output_mode_ff && step_ff == 3'd5);
            ctl.a_load  = output_mode_ff && (step_ff == 3'd4);
            rsp_load    = at_last && rsp_free;
         end
         default: ;
      endcase
   end

   logic [SAMPLE_BITS-1:0] result;

   mwo_interp u_interp (
      .clock      (clock),
      .ctl        (ctl),
      .rd_data    (rd_data),
      .weight     (weight),
      .pulse_mode (output_mode_ff),
      .result     (result)
   );

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_start_reads: assert property (@(posedge clock) disable iff (reset)
      start |=> (state_ff == ST_READ) && (step_ff == '0))
      else $error("producing tick did not start the read sequence");

   a_phase_frozen: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> $stable(phase_ff))
      else $error("phase moved while a tick was being read");

   a_tick_advance: assert property (@(posedge clock) disable iff (reset)
      tick |=> (phase_ff == $past(phase_next)))
      else $error("phase did not advance by the increment");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (step_ff <= last_step))
      else $error("read step beyond the last step");

endmodule

FILE: hw/rtl/mwo_table_ram.sv
// ----------------------------------------------------------------------------
// mwo_table_ram
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mwo_table_ram
   import mwo_pkg::*;
#(
   parameter int ADDR_W = 15,
   parameter int DEPTH  = 32768
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  logic [SAMPLE_BITS-1:0] wr_data,
   input  logic [ADDR_W-1:0]      rd_addr,
   output logic [SAMPLE_BITS-1:0] rd_data
);

   logic [SAMPLE_BITS-1:0] mem [DEPTH];
   logic [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/mwo_select.sv
// ----------------------------------------------------------------------------
// mwo_select
// Table descriptors and band selection by phase increment.
// ----------------------------------------------------------------------------
module mwo_select
   import mwo_pkg::*;
#(
   parameter int TABLE_SLOTS = 8,
   parameter int SLOT_W      = 3,
   parameter int LEN_W       = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  desc_we,
   input  logic [SLOT_W-1:0]     desc_slot,
   input  logic [PHASE_BITS-1:0] desc_top,
   input  logic [LEN_W-1:0]      desc_len,
   input  logic [PHASE_BITS-1:0] phase_inc,
   input  logic [TIU_W-1:0]      tables_in_use,
   input  logic                  sel_en,
   output logic [SLOT_W-1:0]     sel_slot,
   output logic [LEN_W-1:0]      sel_len
);

   logic [PHASE_BITS-1:0] top_ff [TABLE_SLOTS];
   logic [LEN_W-1:0]      len_ff [TABLE_SLOTS];
   logic [SLOT_W-1:0]     sel_slot_ff;
   logic [LEN_W-1:0]      sel_len_ff;
   logic [4:0]            used;
   logic [SLOT_W-1:0]     pick;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            top_ff[i] <= '0;
            len_ff[i] <= '0;
         end
      end else if (desc_we) begin
         top_ff[desc_slot] <= desc_top;
         len_ff[desc_slot] <= desc_len;
      end
   end

   // first table whose top frequency exceeds the increment, else the last in use
   always_comb begin
      used = (5'(tables_in_use) > 5'(TABLE_SLOTS)) ? 5'(TABLE_SLOTS) : 5'(tables_in_use);
      pick = SLOT_W'(TABLE_SLOTS - 1);
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if ((5'(i + 1) >= used) || (phase_inc < top_ff[i])) begin
            pick = SLOT_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sel_en) begin
         sel_slot_ff <= pick;
         sel_len_ff  <= len_ff[pick];
      end
   end

   assign sel_slot = sel_slot_ff;
   assign sel_len  = sel_len_ff;

endmodule

FILE: hw/rtl/mwo_interp.sv
// ----------------------------------------------------------------------------
// mwo_interp
// Linear interpolation datapath and pulse-mode difference with saturation.
// ----------------------------------------------------------------------------
module mwo_interp
   import mwo_pkg::*;
(
   input  logic                   clock,
   input  interp_ctl_type         ctl,
   input  logic [SAMPLE_BITS-1:0] rd_data,
   input  logic [FRAC_BITS-1:0]   weight,
   input  logic                   pulse_mode,
   output logic [SAMPLE_BITS-1:0] result
);

   localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

   logic [SAMPLE_BITS-1:0]   s0_ff;
   logic [SAMPLE_BITS-1:0]   base_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [SAMPLE_BITS-1:0]   sum_ff;
   logic [SAMPLE_BITS-1:0]   a_ff;

   logic signed [SAMPLE_BITS:0] diff;
   logic signed [PROD_W-1:0]    prod_in;
   logic signed [PROD_W-1:0]    prod_shr;
   logic [SAMPLE_BITS:0]        sum_wide;
   logic [SAMPLE_BITS-1:0]      sum_in;
   logic [SAMPLE_BITS:0]        pdiff;

   always_comb begin
      diff     = $signed({rd_data[SAMPLE_BITS-1], rd_data}) -
                 $signed({s0_ff[SAMPLE_BITS-1], s0_ff});
      prod_in  = PROD_W'(diff) * PROD_W'($signed({1'b0, weight}));
      prod_shr = prod_ff >>> FRAC_BITS;
      sum_wide = {base_ff[SAMPLE_BITS-1], base_ff} + prod_shr[SAMPLE_BITS:0];
      sum_in   = sum_wide[SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (ctl.s0_load) begin
         s0_ff <= rd_data;
      end
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
         base_ff <= s0_ff;
      end
      if (ctl.sum_en) begin
         sum_ff <= sum_in;
      end
      if (ctl.a_load) begin
         a_ff <= sum_ff;
      end
   end

   always_comb begin
      pdiff = {a_ff[SAMPLE_BITS-1], a_ff} - {sum_ff[SAMPLE_BITS-1], sum_ff};
      if (!pulse_mode) begin
         result = sum_ff;
      end else if (pdiff[SAMPLE_BITS] != pdiff[SAMPLE_BITS-1]) begin
         result = pdiff[SAMPLE_BITS] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         result = pdiff[SAMPLE_BITS-1:0];
      end
   end

endmodule
